// ===== rtl/rgb_to_hsv_conversion_macros.svh =====
// Assertion macros for the RGB to HSV converter.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef RGB_TO_HSV_CONVERSION_MACROS_SVH
`define RGB_TO_HSV_CONVERSION_MACROS_SVH
`ifndef SYNTHESIS
`define RHC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhc assertion failed");
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhc assertion failed");
`else
`define RHC_ASSERT_IMPLIES(lbl, ante, cons)
`define RHC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rhc_pkg.sv =====
// Shared constants and types for the RGB to HSV converter.
// No dependencies.
package rhc_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int SAT_FRAC_BITS = 12;
    localparam int CH_W          = 8;
    localparam int HUE_W         = 15;
    localparam int SAT_W         = 13;
    localparam int NUM_W         = 17;
    localparam int HUE_DVD_W     = NUM_W + HUE_FRAC_BITS;
    localparam int SAT_DVD_W     = CH_W + SAT_FRAC_BITS;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;
    localparam int FIFO_CW       = 3;

    localparam logic [HUE_W-1:0] HUE_CIRCLE = HUE_W'(360 << HUE_FRAC_BITS);
    localparam logic [NUM_W-1:0] C60        = NUM_W'(60);
    localparam logic [NUM_W-1:0] C120       = NUM_W'(120);
    localparam logic [NUM_W-1:0] C240       = NUM_W'(240);
    localparam logic [NUM_W-1:0] C360       = NUM_W'(360);

    // One classified pixel, ready for the two dividers.
    typedef struct packed {
        logic [HUE_DVD_W-1:0] hue_dvd;
        logic [SAT_DVD_W-1:0] sat_dvd;
        logic [CH_W-1:0]      hue_dvs;
        logic [CH_W-1:0]      sat_dvs;
        logic                 grey;
    } item_t;

endpackage

// ===== rtl/rhc_front.sv =====
// Front end: accepts pixels, finds max/min and builds the dividends.
// Depends on rhc_pkg.
module rhc_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [rhc_pkg::CH_W-1:0]   red,
    input  logic [rhc_pkg::CH_W-1:0]   green,
    input  logic [rhc_pkg::CH_W-1:0]   blue,
    output rhc_pkg::item_t             item,
    output logic                       item_valid,
    input  logic                       item_ready
);

    logic [rhc_pkg::CH_W-1:0]  mx;
    logic [rhc_pkg::CH_W-1:0]  mn;
    logic [rhc_pkg::CH_W-1:0]  d;
    logic [rhc_pkg::NUM_W-1:0] num;
    rhc_pkg::item_t            item_reg;
    rhc_pkg::item_t            item_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      accept;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        d = mx - mn;

        // The sector base is folded in so the numerator is never negative.
        if (mx == red)
        begin
            if (green >= blue)
            begin
                num = rhc_pkg::C60 * rhc_pkg::NUM_W'(green - blue);
            end
            else
            begin
                num = rhc_pkg::C360 * rhc_pkg::NUM_W'(d)
                    - rhc_pkg::C60 * rhc_pkg::NUM_W'(blue - green);
            end
        end
        else if (mx == green)
        begin
            if (blue >= red)
            begin
                num = rhc_pkg::C120 * rhc_pkg::NUM_W'(d)
                    + rhc_pkg::C60 * rhc_pkg::NUM_W'(blue - red);
            end
            else
            begin
                num = rhc_pkg::C120 * rhc_pkg::NUM_W'(d)
                    - rhc_pkg::C60 * rhc_pkg::NUM_W'(red - blue);
            end
        end
        else
        begin
            if (red >= green)
            begin
                num = rhc_pkg::C240 * rhc_pkg::NUM_W'(d)
                    + rhc_pkg::C60 * rhc_pkg::NUM_W'(red - green);
            end
            else
            begin
                num = rhc_pkg::C240 * rhc_pkg::NUM_W'(d)
                    - rhc_pkg::C60 * rhc_pkg::NUM_W'(green - red);
            end
        end
    end

    assign full   = valid_reg && !item_ready;
    assign accept = push && !full;

    always_comb
    begin
        item_next         = item_reg;
        valid_next        = valid_reg;
        if (accept)
        begin
            item_next.hue_dvd = {num, rhc_pkg::HUE_FRAC_BITS'(0)}
                              + rhc_pkg::HUE_DVD_W'(d >> 1);
            item_next.sat_dvd = {d, rhc_pkg::SAT_FRAC_BITS'(0)}
                              + rhc_pkg::SAT_DVD_W'(mx >> 1);
            item_next.hue_dvs = d;
            item_next.sat_dvs = mx;
            item_next.grey    = (d == '0);
            valid_next        = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== rtl/rhc_fifo.sv =====
// Short queue between the front end and the divider pipeline.
// Depends on rhc_pkg.
module rhc_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  rhc_pkg::item_t wr_item,
    input  logic           wr_valid,
    output logic           wr_ready,
    output rhc_pkg::item_t rd_item,
    output logic           rd_valid,
    input  logic           rd_ready
);

    rhc_pkg::item_t                mem_reg [rhc_pkg::FIFO_DEPTH];
    logic [rhc_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [rhc_pkg::FIFO_AW-1:0]   wr_ptr_next;
    logic [rhc_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [rhc_pkg::FIFO_AW-1:0]   rd_ptr_next;
    logic [rhc_pkg::FIFO_CW-1:0]   count_reg;
    logic [rhc_pkg::FIFO_CW-1:0]   count_next;
    logic                          do_wr;
    logic                          do_rd;

    assign wr_ready = (count_reg != rhc_pkg::FIFO_CW'(rhc_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/rhc_div.sv =====
// Back end: pipelined restoring dividers for hue and saturation, one
// hue quotient bit per stage, followed by the output register. Depends on rhc_pkg.
module rhc_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rhc_pkg::item_t              in_item,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        empty,
    input  logic                        pop,
    output logic [rhc_pkg::HUE_W-1:0]   hue,
    output logic [rhc_pkg::SAT_W-1:0]   saturation,
    output logic [rhc_pkg::CH_W-1:0]    value
);

    localparam int NS = rhc_pkg::HUE_W;

    logic [rhc_pkg::HUE_DVD_W-1:0] hrem_reg [NS];
    logic [rhc_pkg::SAT_DVD_W-1:0] srem_reg [NS];
    logic [rhc_pkg::HUE_W-1:0]     hq_reg   [NS];
    logic [rhc_pkg::SAT_W-1:0]     sq_reg   [NS];
    logic [rhc_pkg::CH_W-1:0]      hdvs_reg [NS];
    logic [rhc_pkg::CH_W-1:0]      sdvs_reg [NS];
    logic                          grey_reg [NS];
    logic                          vld_reg  [NS];

    logic                          out_valid_reg;
    logic [rhc_pkg::HUE_W-1:0]     hue_reg;
    logic [rhc_pkg::HUE_W-1:0]     hue_next;
    logic [rhc_pkg::SAT_W-1:0]     sat_reg;
    logic [rhc_pkg::SAT_W-1:0]     sat_next;
    logic [rhc_pkg::CH_W-1:0]      val_reg;
    logic                          en;

    // The whole pipeline advances together unless a result waits unread.
    assign en       = !out_valid_reg || pop;
    assign in_ready = en;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int BIT = NS - 1 - k;

        logic [rhc_pkg::HUE_DVD_W-1:0] h_in;
        logic [rhc_pkg::HUE_DVD_W-1:0] h_sub;
        logic [rhc_pkg::SAT_DVD_W-1:0] s_in;
        logic [rhc_pkg::SAT_DVD_W-1:0] s_sub;
        logic [rhc_pkg::HUE_W-1:0]     hq_in;
        logic [rhc_pkg::SAT_W-1:0]     sq_in;
        logic [rhc_pkg::CH_W-1:0]      hdvs_in;
        logic [rhc_pkg::CH_W-1:0]      sdvs_in;
        logic                          grey_in;
        logic                          vld_in;
        logic [rhc_pkg::HUE_DVD_W-1:0] h_next;
        logic [rhc_pkg::SAT_DVD_W-1:0] s_next;
        logic [rhc_pkg::HUE_W-1:0]     hq_next;
        logic [rhc_pkg::SAT_W-1:0]     sq_next;

        if (k == 0)
        begin : g_first
            assign h_in    = in_item.hue_dvd;
            assign s_in    = in_item.sat_dvd;
            assign hq_in   = '0;
            assign sq_in   = '0;
            assign hdvs_in = in_item.hue_dvs;
            assign sdvs_in = in_item.sat_dvs;
            assign grey_in = in_item.grey;
            assign vld_in  = in_valid;
        end
        else
        begin : g_next
            assign h_in    = hrem_reg[k-1];
            assign s_in    = srem_reg[k-1];
            assign hq_in   = hq_reg[k-1];
            assign sq_in   = sq_reg[k-1];
            assign hdvs_in = hdvs_reg[k-1];
            assign sdvs_in = sdvs_reg[k-1];
            assign grey_in = grey_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign h_sub = rhc_pkg::HUE_DVD_W'(hdvs_in) << BIT;

        always_comb
        begin
            h_next  = h_in;
            hq_next = hq_in;
            if (h_in >= h_sub)
            begin
                h_next       = h_in - h_sub;
                hq_next[BIT] = 1'b1;
            end
        end

        if (BIT < rhc_pkg::SAT_W)
        begin : g_sat
            assign s_sub = rhc_pkg::SAT_DVD_W'(sdvs_in) << BIT;

            always_comb
            begin
                s_next  = s_in;
                sq_next = sq_in;
                if (s_in >= s_sub)
                begin
                    s_next       = s_in - s_sub;
                    sq_next[BIT] = 1'b1;
                end
            end
        end
        else
        begin : g_nosat
            assign s_sub   = '0;
            assign s_next  = s_in | s_sub;
            assign sq_next = sq_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hrem_reg[k] <= h_next;
                srem_reg[k] <= s_next;
                hq_reg[k]   <= hq_next;
                sq_reg[k]   <= sq_next;
                hdvs_reg[k] <= hdvs_in;
                sdvs_reg[k] <= sdvs_in;
                grey_reg[k] <= grey_in;
            end
        end
    end

    // Grey and black pixels have no valid quotient; both fields are zero.
    always_comb
    begin
        hue_next = hq_reg[NS-1];
        if (hq_reg[NS-1] >= rhc_pkg::HUE_CIRCLE)
        begin
            hue_next = hq_reg[NS-1] - rhc_pkg::HUE_CIRCLE;
        end
        sat_next = sq_reg[NS-1];
        if (grey_reg[NS-1])
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= sdvs_reg[NS-1];
        end
    end

    assign empty      = !out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign value      = val_reg;

endmodule

// ===== rtl/rgb_to_hsv_conversion.sv =====
// RGB to HSV converter, top level.
// Instantiates rhc_front, rhc_fifo and rhc_div; uses rhc_pkg and the macro header.
//
// Usage: the input side behaves like the write side of a queue. A pixel
// (red, green, blue) is taken at a rising edge where push is high and full
// is low. The result side behaves like the read side of a queue: while empty
// is low, hue, saturation and value show the oldest result, and it is taken
// at a rising edge where pop is high. Each input beat yields one result beat.
// Hue is in 1/64 degree units, saturation is scaled by 4096 and value is the
// largest channel.
// From the input beat until empty drops, a pixel passes the front register,
// one queue slot and the fifteen-stage divider pipeline (one hue quotient
// bit per stage), then the output register.
// Throughput is one pixel per cycle for as long as the reader keeps popping.
// When the reader stalls, the divider pipeline holds, the four-entry queue
// fills, and then full rises; no beat is lost or repeated.
// Reset clears all valid flags: the block comes up empty and not full.
`include "rgb_to_hsv_conversion_macros.svh"

module rgb_to_hsv_conversion
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [rhc_pkg::CH_W-1:0]    red,
    input  logic [rhc_pkg::CH_W-1:0]    green,
    input  logic [rhc_pkg::CH_W-1:0]    blue,
    output logic                        empty,
    input  logic                        pop,
    output logic [rhc_pkg::HUE_W-1:0]   hue,
    output logic [rhc_pkg::SAT_W-1:0]   saturation,
    output logic [rhc_pkg::CH_W-1:0]    value
);

    rhc_pkg::item_t front_item;
    logic           front_valid;
    logic           fifo_wr_ready;
    rhc_pkg::item_t fifo_item;
    logic           fifo_valid;
    logic           div_ready;
    logic           fifo_pop;

    // The front end classifies each pixel and forms both dividends.
    rhc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (fifo_wr_ready)
    );

    // The queue decouples the front end from stalls in the back end.
    rhc_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (fifo_wr_ready),
        .rd_item  (fifo_item),
        .rd_valid (fifo_valid),
        .rd_ready (div_ready)
    );

    // The back end runs the two divisions and holds the result for the reader.
    rhc_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (fifo_item),
        .in_valid   (fifo_valid),
        .in_ready   (div_ready),
        .empty      (empty),
        .pop        (pop),
        .hue        (hue),
        .saturation (saturation),
        .value      (value)
    );

    assign fifo_pop = fifo_valid && div_ready;

    // A shown hue is always below a full circle.
    `RHC_ASSERT_IMPLIES(a_hue_range, !empty, hue < rhc_pkg::HUE_CIRCLE)
    // Saturation never exceeds one.
    `RHC_ASSERT_IMPLIES(a_sat_range, !empty,
        saturation <= rhc_pkg::SAT_W'(1 << rhc_pkg::SAT_FRAC_BITS))
    // Zero saturation only happens for grey pixels, whose hue is zero.
    `RHC_ASSERT_IMPLIES(a_grey_hue, !empty && (saturation == '0), hue == '0)
    // Full only drops once the queue has released an entry.
    `RHC_ASSERT_NEXT(a_full_hold, full && !fifo_pop, full)

endmodule
